@@ hw/rtl/pfr_pkg.sv @@
// ============================================================================
// pfr_pkg: shared types and constants of the page fault replacement block
// Sizes, register indexes, controller states, command and status groups and
// small helper functions used by the controller and the datapath.
// ============================================================================
package pfr_pkg;

  // Table sizes.
  localparam int NUM_PAGES  = 256;
  localparam int PAGE_W     = 8;
  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = 6;
  localparam int FCNT_W     = 7;
  localparam int CNT_W      = 32;

  // Random generator.
  localparam int            LFSR_W       = 16;
  localparam logic [15:0]   SEED_DEFAULT = 16'hACE1;
  localparam logic [15:0]   LFSR_TAPS    = 16'hB400;

  // Remainder unit: dividend bits consumed per cycle and cycle count.
  localparam int REM_STEP  = 4;
  localparam int REM_CYC   = LFSR_W / REM_STEP;
  localparam int REM_CNT_W = $clog2(REM_CYC);

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_POLICY = 2'd0,
    CFG_FRAMES = 2'd1,
    CFG_SEED   = 2'd2
  } cfg_idx_t;

  // Victim selection policy codes.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_RAND = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MOD,
    ST_OWN,
    ST_VIC,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic take_resident;
    logic take_fill;
    logic start_rand;
    logic take_fifo;
    logic take_rem;
    logic own_rd;
    logic victim;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic resident;
    logic fill_avail;
    logic rand_mode;
    logic rem_done;
    logic out_busy;
  } sts_t;

  // Galois LFSR step, shifting right.
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  // A zero seed falls back to the default so the generator never locks up.
  function automatic logic [LFSR_W-1:0] seed_value(input logic [LFSR_W-1:0] s);
    return (s == '0) ? SEED_DEFAULT : s;
  endfunction

  // Frame count clamped to the range 1 to NUM_FRAMES.
  function automatic logic [FCNT_W-1:0] frame_clamp(input logic [FCNT_W-1:0] n);
    logic [FCNT_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = FCNT_W'(1);
    end else if (n > FCNT_W'(NUM_FRAMES)) begin
      r = FCNT_W'(NUM_FRAMES);
    end
    return r;
  endfunction

  // Saturating increment of an event counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + CNT_W'(1);
  endfunction

endpackage

@@ hw/rtl/pfr_rem.sv @@
// ============================================================================
// pfr_rem: iterative remainder unit
// Computes the random value modulo the frame count by restoring division,
// several dividend bits per cycle, and pulses done when the remainder is ready.
// ============================================================================
module pfr_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pfr_pkg::LFSR_W-1:0]   dividend,
  input  logic [pfr_pkg::FCNT_W-1:0]   divisor,
  output logic                         done,
  output logic [pfr_pkg::FRAME_W-1:0]  rem
);

  logic                            busy_r;
  logic                            done_r;
  logic [pfr_pkg::REM_CNT_W-1:0]   cnt_r;
  logic [pfr_pkg::LFSR_W-1:0]      dvd_r;
  logic [pfr_pkg::FRAME_W-1:0]     rem_r;
  logic [pfr_pkg::FCNT_W-1:0]      d_r;
  logic [pfr_pkg::FRAME_W-1:0]     rem_nxt;

  // A few restoring steps per cycle; the partial remainder stays below the divisor.
  always_comb begin
    logic [pfr_pkg::FRAME_W-1:0] r;
    logic [pfr_pkg::FCNT_W-1:0]  t;
    r = rem_r;
    for (int i = 0; i < pfr_pkg::REM_STEP; i++) begin
      t = {r, dvd_r[pfr_pkg::LFSR_W-1-i]};
      if (t >= d_r) begin
        r = pfr_pkg::FRAME_W'(t - d_r);
      end else begin
        r = t[pfr_pkg::FRAME_W-1:0];
      end
    end
    rem_nxt = r;
  end

  // Control: busy flag, step counter and done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + pfr_pkg::REM_CNT_W'(1);
        if (cnt_r == pfr_pkg::REM_CNT_W'(pfr_pkg::REM_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shift register, partial remainder and divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_r << pfr_pkg::REM_STEP;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  // The finished remainder is always below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < d_r))
    else $error("remainder not below divisor");

endmodule

@@ hw/rtl/pfr_dpath.sv @@
// ============================================================================
// pfr_dpath: page fault replacement datapath
// Holds the configuration, page and frame tables, fill and round-robin state,
// the random generator, event counters and the output register.
// ============================================================================
module pfr_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfr_pkg::cmd_t                   cmd,
  output pfr_pkg::sts_t                   sts,
  input  logic                            cfg_we,
  input  logic [pfr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [pfr_pkg::PAGE_W-1:0]      in_fault_page,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [pfr_pkg::FRAME_W-1:0]     out_mapped_frame,
  output logic                            out_write_granted,
  output logic                            out_load_from_disk,
  output logic                            out_evicted,
  output logic                            out_write_back,
  output logic [pfr_pkg::PAGE_W-1:0]      out_removed_page,
  output logic [pfr_pkg::CNT_W-1:0]       out_fault_total,
  output logic [pfr_pkg::CNT_W-1:0]       out_read_total,
  output logic [pfr_pkg::CNT_W-1:0]       out_write_total
);

  // Configuration registers.
  logic                          policy_r;
  logic [pfr_pkg::FCNT_W-1:0]    frames_r;

  // Tables.
  logic [pfr_pkg::FRAME_W-1:0]   pf_mem  [pfr_pkg::NUM_PAGES];
  logic [pfr_pkg::PAGE_W-1:0]    own_mem [pfr_pkg::NUM_FRAMES];
  logic [pfr_pkg::NUM_PAGES-1:0] res_r;
  logic [pfr_pkg::NUM_PAGES-1:0] dirty_r;
  logic [pfr_pkg::FRAME_W-1:0]   pf_rdata_r;
  logic [pfr_pkg::PAGE_W-1:0]    own_rdata_r;

  // Allocation state.
  logic [pfr_pkg::FCNT_W-1:0]    fill_r;
  logic [pfr_pkg::FRAME_W-1:0]   ptr_r;
  logic [pfr_pkg::LFSR_W-1:0]    lfsr_r;
  logic [pfr_pkg::LFSR_W-1:0]    lfsr_nxt;

  // Working item.
  logic [pfr_pkg::PAGE_W-1:0]    page_r;
  logic [pfr_pkg::FRAME_W-1:0]   frame_r;
  logic                          granted_r;
  logic                          load_r;
  logic                          evict_r;
  logic                          wb_r;
  logic [pfr_pkg::PAGE_W-1:0]    victim_r;

  // Counters and output register.
  logic [pfr_pkg::CNT_W-1:0]     fault_cnt_r;
  logic [pfr_pkg::CNT_W-1:0]     read_cnt_r;
  logic [pfr_pkg::CNT_W-1:0]     write_cnt_r;
  logic                          out_valid_r;
  logic [pfr_pkg::FRAME_W-1:0]   out_frame_r;
  logic                          out_granted_r;
  logic                          out_load_r;
  logic                          out_evict_r;
  logic                          out_wb_r;
  logic [pfr_pkg::PAGE_W-1:0]    out_victim_r;

  // Derived values.
  logic [pfr_pkg::FCNT_W-1:0]    limit;
  logic [pfr_pkg::FRAME_W-1:0]   fifo_frame;
  logic [pfr_pkg::FRAME_W-1:0]   fifo_nxt;
  logic [pfr_pkg::FCNT_W-1:0]    fifo_inc;
  logic                          rem_done;
  logic [pfr_pkg::FRAME_W-1:0]   rem_val;

  assign limit      = pfr_pkg::frame_clamp(frames_r);
  assign lfsr_nxt   = pfr_pkg::lfsr_next(lfsr_r);
  assign fifo_frame = ({1'b0, ptr_r} < limit) ? ptr_r : '0;
  assign fifo_inc   = pfr_pkg::FCNT_W'(fifo_frame) + pfr_pkg::FCNT_W'(1);
  assign fifo_nxt   = (fifo_inc >= limit) ? '0 : fifo_inc[pfr_pkg::FRAME_W-1:0];

  // Victim frame modulo the frame count in random mode.
  pfr_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_rand),
    .dividend (lfsr_nxt),
    .divisor  (limit),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // Status toward the controller.
  always_comb begin
    sts.resident   = res_r[page_r];
    sts.fill_avail = (fill_r < limit);
    sts.rand_mode  = (policy_r == pfr_pkg::POLICY_RAND);
    sts.rem_done   = rem_done;
    sts.out_busy   = out_valid_r && out_stall;
  end

  // Configuration, allocation state and random generator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= pfr_pkg::POLICY_FIFO;
      frames_r <= pfr_pkg::FCNT_W'(pfr_pkg::NUM_FRAMES);
      lfsr_r   <= pfr_pkg::seed_value(pfr_pkg::SEED_DEFAULT);
      fill_r   <= '0;
      ptr_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          pfr_pkg::CFG_POLICY: policy_r <= cfg_wdata[0];
          pfr_pkg::CFG_FRAMES: frames_r <= cfg_wdata[pfr_pkg::FCNT_W-1:0];
          pfr_pkg::CFG_SEED:   lfsr_r   <= pfr_pkg::seed_value(cfg_wdata);
          default: ;
        endcase
      end else if (cmd.start_rand) begin
        lfsr_r <= lfsr_nxt;
      end
      if (cmd.take_fill) begin
        fill_r <= fill_r + pfr_pkg::FCNT_W'(1);
      end
      if (cmd.take_fifo) begin
        ptr_r <= fifo_nxt;
      end
    end
  end

  // Page table: written when a loading item commits, read when an item is accepted.
  always_ff @(posedge clk) begin
    if (cmd.commit && load_r) begin
      pf_mem[page_r] <= frame_r;
    end
    if (cmd.accept) begin
      pf_rdata_r <= pf_mem[in_fault_page];
    end
  end

  // Frame owner table: written when a loading item commits, read before the victim step.
  always_ff @(posedge clk) begin
    if (cmd.commit && load_r) begin
      own_mem[frame_r] <= page_r;
    end
    if (cmd.own_rd) begin
      own_rdata_r <= own_mem[frame_r];
    end
  end

  // Resident and dirty flags per page.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r   <= '0;
      dirty_r <= '0;
    end else begin
      if (cmd.victim) begin
        res_r[own_rdata_r]   <= 1'b0;
        dirty_r[own_rdata_r] <= 1'b0;
      end
      if (cmd.commit) begin
        if (load_r) begin
          res_r[page_r]   <= 1'b1;
          dirty_r[page_r] <= 1'b0;
        end else begin
          dirty_r[page_r] <= 1'b1;
        end
      end
    end
  end

  // Working item: page, chosen frame and the result flags.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r <= in_fault_page;
    end
    if (cmd.take_resident) begin
      frame_r   <= pf_rdata_r;
      granted_r <= 1'b1;
      load_r    <= 1'b0;
      evict_r   <= 1'b0;
      wb_r      <= 1'b0;
      victim_r  <= '0;
    end
    if (cmd.take_fill) begin
      frame_r   <= fill_r[pfr_pkg::FRAME_W-1:0];
      granted_r <= 1'b0;
      load_r    <= 1'b1;
      evict_r   <= 1'b0;
      wb_r      <= 1'b0;
      victim_r  <= '0;
    end
    if (cmd.start_rand || cmd.take_fifo) begin
      granted_r <= 1'b0;
      load_r    <= 1'b1;
      evict_r   <= 1'b1;
      wb_r      <= 1'b0;
      victim_r  <= '0;
    end
    if (cmd.take_fifo) begin
      frame_r <= fifo_frame;
    end
    if (cmd.take_rem) begin
      frame_r <= rem_val;
    end
    if (cmd.victim) begin
      victim_r <= own_rdata_r;
      wb_r     <= dirty_r[own_rdata_r];
    end
  end

  // Event counters; they change only on commit, so they also serve as outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_cnt_r <= '0;
      read_cnt_r  <= '0;
      write_cnt_r <= '0;
    end else if (cmd.commit) begin
      fault_cnt_r <= pfr_pkg::sat_inc(fault_cnt_r);
      if (load_r) begin
        read_cnt_r <= pfr_pkg::sat_inc(read_cnt_r);
      end
      if (wb_r) begin
        write_cnt_r <= pfr_pkg::sat_inc(write_cnt_r);
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_frame_r   <= frame_r;
      out_granted_r <= granted_r;
      out_load_r    <= load_r;
      out_evict_r   <= evict_r;
      out_wb_r      <= wb_r;
      out_victim_r  <= victim_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mapped_frame   = out_frame_r;
  assign out_write_granted  = out_granted_r;
  assign out_load_from_disk = out_load_r;
  assign out_evicted        = out_evict_r;
  assign out_write_back     = out_wb_r;
  assign out_removed_page   = out_victim_r;
  assign out_fault_total    = fault_cnt_r;
  assign out_read_total     = read_cnt_r;
  assign out_write_total    = write_cnt_r;

  // A loaded page is resident once its item commits.
  a_load_resident: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && load_r) |=> res_r[page_r])
    else $error("loaded page not marked resident");

  // The victim page is no longer resident once it has been chosen.
  a_victim_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.victim |=> !res_r[victim_r])
    else $error("victim page still resident");

endmodule

@@ hw/rtl/pfr_ctrl.sv @@
// ============================================================================
// pfr_ctrl: page fault replacement controller
// Sequences one item at a time through lookup, victim choice, owner read and
// commit, and drives the input stall.
// ============================================================================
module pfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pfr_pkg::sts_t  sts,
  output pfr_pkg::cmd_t  cmd
);

  pfr_pkg::state_t state_r;
  pfr_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != pfr_pkg::ST_IDLE);
    unique case (state_r)
      pfr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = pfr_pkg::ST_LOOK;
        end
      end
      pfr_pkg::ST_LOOK: begin
        priority if (sts.resident) begin
          cmd.take_resident = 1'b1;
          state_nxt         = pfr_pkg::ST_COMMIT;
        end else if (sts.fill_avail) begin
          cmd.take_fill = 1'b1;
          state_nxt     = pfr_pkg::ST_COMMIT;
        end else if (sts.rand_mode) begin
          cmd.start_rand = 1'b1;
          state_nxt      = pfr_pkg::ST_MOD;
        end else begin
          cmd.take_fifo = 1'b1;
          state_nxt     = pfr_pkg::ST_OWN;
        end
      end
      pfr_pkg::ST_MOD: begin
        if (sts.rem_done) begin
          cmd.take_rem = 1'b1;
          state_nxt    = pfr_pkg::ST_OWN;
        end
      end
      pfr_pkg::ST_OWN: begin
        cmd.own_rd = 1'b1;
        state_nxt  = pfr_pkg::ST_VIC;
      end
      pfr_pkg::ST_VIC: begin
        cmd.victim = 1'b1;
        state_nxt  = pfr_pkg::ST_COMMIT;
      end
      pfr_pkg::ST_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = pfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pfr_pkg::ST_IDLE;
    endcase
  end

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.out_busy)
    else $error("commit while output register is held");

  // An accepted item goes to lookup in the next cycle.
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == pfr_pkg::ST_LOOK))
    else $error("accepted item did not enter lookup");

endmodule

@@ hw/rtl/page_fault_fifo_random_replacement_top.sv @@
// ============================================================================
// page_fault_fifo_random_replacement_top: page fault handler with FIFO or
// pseudo-random frame replacement
// Joins the controller and the datapath and exposes the item channels and the
// configuration write port.
// ============================================================================
// A resident page or a free frame goes from lookup straight to commit. A FIFO
// eviction adds the frame owner memory read and the victim step; a random eviction
// adds the same steps after waiting for the remainder unit, which takes 4 dividend
// bits a cycle. One item is in work at a time; the next item is accepted while the
// previous result waits in the output register.
// Reset (synchronous, active low) clears all page flags, counters and fill state.
module page_fault_fifo_random_replacement_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pfr_pkg::PAGE_W-1:0]      in_fault_page,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfr_pkg::FRAME_W-1:0]     out_mapped_frame,
  output logic                            out_write_granted,
  output logic                            out_load_from_disk,
  output logic                            out_evicted,
  output logic                            out_write_back,
  output logic [pfr_pkg::PAGE_W-1:0]      out_removed_page,
  output logic [pfr_pkg::CNT_W-1:0]       out_fault_total,
  output logic [pfr_pkg::CNT_W-1:0]       out_read_total,
  output logic [pfr_pkg::CNT_W-1:0]       out_write_total,
  input  logic                            cfg_we,
  input  logic [pfr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pfr_pkg::cmd_t cmd;
  pfr_pkg::sts_t sts;

  // Sequencer.
  pfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, counters and output register.
  pfr_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_fault_page      (in_fault_page),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_mapped_frame   (out_mapped_frame),
    .out_write_granted  (out_write_granted),
    .out_load_from_disk (out_load_from_disk),
    .out_evicted        (out_evicted),
    .out_write_back     (out_write_back),
    .out_removed_page   (out_removed_page),
    .out_fault_total    (out_fault_total),
    .out_read_total     (out_read_total),
    .out_write_total    (out_write_total)
  );

endmodule
